FILE: design/mstb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstb_pkg
// Shared types and constants of the sample table builder.
// ----------------------------------------------------------------------------
package mstb_pkg;

   localparam int MODE_SAMPLE = 0;
   localparam int MODE_END    = 1;

   localparam logic [2:0] TABLE_TIME    = 3'd0;
   localparam logic [2:0] TABLE_OFFSET  = 3'd1;
   localparam logic [2:0] TABLE_SYNC    = 3'd2;
   localparam logic [2:0] TABLE_SIZE    = 3'd3;
   localparam logic [2:0] TABLE_SUMMARY = 3'd4;

   localparam int SLOTS        = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic        mode;
      logic [63:0] pts;
      logic [31:0] cto;
      logic [31:0] byte_size;
      logic        is_sync;
   } req_type;

   typedef struct packed {
      logic [2:0]  table_res;
      logic [31:0] count;
      logic [63:0] value;
      logic        sizes_uniform;
      logic [31:0] uniform_size;
      logic        offsets_present;
      logic        sync_table_present;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  table_res;
      logic [31:0] count;
      logic [63:0] value;
   } slot_type;

   // All words caused by one input item, in emission order by slot index.
   typedef struct packed {
      logic [SLOTS-1:0] slot_valid;
      slot_type [SLOTS-1:0] slot;
      logic        sizes_uniform;
      logic [31:0] uniform_size;
      logic        offsets_present;
      logic        sync_table_present;
   } bundle_type;

endpackage
`default_nettype wire

FILE: design/mstb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstb_front
// Accepts samples, tracks the open runs and builds the bundle of table words.
// ----------------------------------------------------------------------------
module mstb_front
   import mstb_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire req_type    req_data,
   output logic            q_push,
   output bundle_type      q_data,
   input  wire logic       q_full
);

   logic        have_sample_ff, have_sample_in;
   logic [63:0] first_pts_ff, first_pts_in;
   logic [63:0] prev_pts_ff, prev_pts_in;
   logic        time_run_open_ff, time_run_open_in;
   logic [31:0] time_run_duration_ff, time_run_duration_in;
   logic [31:0] time_run_count_ff, time_run_count_in;
   logic [31:0] offset_run_value_ff, offset_run_value_in;
   logic [31:0] offset_run_count_ff, offset_run_count_in;
   logic [31:0] sample_number_ff, sample_number_in;
   logic [31:0] sync_total_ff, sync_total_in;
   logic [31:0] first_size_ff, first_size_in;
   logic        size_mixed_ff, size_mixed_in;
   logic        any_offset_ff, any_offset_in;

   logic        accept;
   logic [31:0] delta;
   logic        t_open;
   logic [31:0] t_dur;
   logic [31:0] t_cnt;
   logic [31:0] sn;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   assign full   = q_full;
   assign accept = push && !q_full;
   assign q_push = accept;
   assign delta  = req_data.pts[31:0] - prev_pts_ff[31:0];

   always_comb begin
      have_sample_in       = have_sample_ff;
      first_pts_in         = first_pts_ff;
      prev_pts_in          = prev_pts_ff;
      time_run_open_in     = time_run_open_ff;
      time_run_duration_in = time_run_duration_ff;
      time_run_count_in    = time_run_count_ff;
      offset_run_value_in  = offset_run_value_ff;
      offset_run_count_in  = offset_run_count_ff;
      sample_number_in     = sample_number_ff;
      sync_total_in        = sync_total_ff;
      first_size_in        = first_size_ff;
      size_mixed_in        = size_mixed_ff;
      any_offset_in        = any_offset_ff;
      q_data               = '0;
      t_open               = time_run_open_ff;
      t_dur                = time_run_duration_ff;
      t_cnt                = time_run_count_ff;
      sn                   = sat_inc(sample_number_ff);

      if (have_sample_ff) begin
         if (time_run_open_ff && delta == time_run_duration_ff) begin
            t_cnt = sat_inc(time_run_count_ff);
         end else begin
            q_data.slot_valid[0] = time_run_open_ff;
            q_data.slot[0]       = '{TABLE_TIME, time_run_count_ff,
                                     {32'd0, time_run_duration_ff}};
            t_open = 1'b1;
            t_dur  = delta;
            t_cnt  = 32'd1;
         end
      end

      if (req_data.mode == 1'(MODE_SAMPLE)) begin
         if (!have_sample_ff) begin
            have_sample_in = 1'b1;
            first_pts_in   = req_data.pts;
            first_size_in  = req_data.byte_size;
         end else if (req_data.byte_size != first_size_ff) begin
            size_mixed_in = 1'b1;
         end
         time_run_open_in     = t_open;
         time_run_duration_in = t_dur;
         time_run_count_in    = t_cnt;
         prev_pts_in          = req_data.pts;

         if (offset_run_count_ff != 32'd0 && req_data.cto == offset_run_value_ff) begin
            offset_run_count_in = sat_inc(offset_run_count_ff);
         end else begin
            q_data.slot_valid[1] = (offset_run_count_ff != 32'd0);
            q_data.slot[1]       = '{TABLE_OFFSET, offset_run_count_ff,
                                     {32'd0, offset_run_value_ff}};
            offset_run_value_in  = req_data.cto;
            offset_run_count_in  = 32'd1;
         end
         if (req_data.cto != 32'd0) begin
            any_offset_in = 1'b1;
         end

         sample_number_in = sn;
         if (req_data.is_sync) begin
            sync_total_in        = sat_inc(sync_total_ff);
            q_data.slot_valid[2] = 1'b1;
            q_data.slot[2]       = '{TABLE_SYNC, sn, 64'd0};
         end
         q_data.slot_valid[3] = 1'b1;
         q_data.slot[3]       = '{TABLE_SIZE, 32'd0, {32'd0, req_data.byte_size}};
      end else begin
         q_data.slot_valid[1] = t_open;
         q_data.slot[1]       = '{TABLE_TIME, t_cnt, {32'd0, t_dur}};
         q_data.slot_valid[2] = (offset_run_count_ff != 32'd0);
         q_data.slot[2]       = '{TABLE_OFFSET, offset_run_count_ff,
                                  {32'd0, offset_run_value_ff}};
         q_data.slot_valid[3] = 1'b1;
         q_data.slot[3]       = '{TABLE_SUMMARY, sample_number_ff,
                                  have_sample_ff ? req_data.pts - first_pts_ff : 64'd0};
         q_data.sizes_uniform      = !size_mixed_ff;
         q_data.uniform_size       = first_size_ff;
         q_data.offsets_present    = any_offset_ff;
         q_data.sync_table_present = (sync_total_ff != sample_number_ff);

         have_sample_in       = 1'b0;
         first_pts_in         = '0;
         prev_pts_in          = '0;
         time_run_open_in     = 1'b0;
         time_run_duration_in = '0;
         time_run_count_in    = '0;
         offset_run_value_in  = '0;
         offset_run_count_in  = '0;
         sample_number_in     = '0;
         sync_total_in        = '0;
         first_size_in        = '0;
         size_mixed_in        = 1'b0;
         any_offset_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_sample_ff       <= 1'b0;
         first_pts_ff         <= '0;
         prev_pts_ff          <= '0;
         time_run_open_ff     <= 1'b0;
         time_run_duration_ff <= '0;
         time_run_count_ff    <= '0;
         offset_run_value_ff  <= '0;
         offset_run_count_ff  <= '0;
         sample_number_ff     <= '0;
         sync_total_ff        <= '0;
         first_size_ff        <= '0;
         size_mixed_ff        <= 1'b0;
         any_offset_ff        <= 1'b0;
      end else if (accept) begin
         have_sample_ff       <= have_sample_in;
         first_pts_ff         <= first_pts_in;
         prev_pts_ff          <= prev_pts_in;
         time_run_open_ff     <= time_run_open_in;
         time_run_duration_ff <= time_run_duration_in;
         time_run_count_ff    <= time_run_count_in;
         offset_run_value_ff  <= offset_run_value_in;
         offset_run_count_ff  <= offset_run_count_in;
         sample_number_ff     <= sample_number_in;
         sync_total_ff        <= sync_total_in;
         first_size_ff        <= first_size_in;
         size_mixed_ff        <= size_mixed_in;
         any_offset_ff        <= any_offset_in;
      end
   end

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.mode == 1'(MODE_END) |=> !have_sample_ff && sample_number_ff == 32'd0)
      else $error("track state not cleared after end item");
   a_sync_bound: assert property (@(posedge clock) disable iff (reset)
      sync_total_ff <= sample_number_ff)
      else $error("sync total exceeds sample number");
   a_run_needs_sample: assert property (@(posedge clock) disable iff (reset)
      time_run_open_ff |-> have_sample_ff && sample_number_ff >= 32'd2)
      else $error("time run open without two samples");

endmodule
`default_nettype wire

FILE: design/mstb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstb_queue
// Short bundle queue between front and back.
// ----------------------------------------------------------------------------
module mstb_queue
   import mstb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire bundle_type  push_data,
   output logic             full,
   input  wire logic        pop,
   output bundle_type       pop_data,
   output logic             valid
);

   bundle_type             mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
   endfunction

   assign full     = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("bundle queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !valid))
      else $error("bundle queue underflow");

endmodule
`default_nettype wire

FILE: design/mstb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstb_back
// Walks each bundle's valid slots; one result word per cycle unless stalled.
// ----------------------------------------------------------------------------
module mstb_back
   import mstb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire bundle_type  q_data,
   output logic             q_pop,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data
);

   bundle_type        cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;
   logic [SLOTS-1:0]  mask_ff, mask_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic                     load_out;
   logic                     take_slot;
   logic [$clog2(SLOTS)-1:0] idx;
   logic [SLOTS-1:0]         rest;
   logic                     last_slot;
   slot_type                 sel;

   always_comb begin
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            idx = ($clog2(SLOTS))'(i);
         end
      end
   end

   assign sel       = cur_ff.slot[idx];
   assign rest      = mask_ff & ~(SLOTS'(1) << idx);
   assign last_slot = (rest == '0);
   assign load_out  = !out_valid_ff || pop;
   assign take_slot = load_out && cur_valid_ff;
   assign q_pop     = q_valid && (!cur_valid_ff || (take_slot && last_slot));
   assign empty     = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      mask_in      = mask_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;

      if (take_slot) begin
         mask_in      = rest;
         cur_valid_in = !last_slot;
      end
      if (q_pop) begin
         cur_in       = q_data;
         mask_in      = q_data.slot_valid;
         cur_valid_in = 1'b1;
      end

      if (load_out) begin
         out_valid_in = take_slot;
         out_in       = '0;
         out_in.table_res = sel.table_res;
         out_in.count     = sel.count;
         out_in.value     = sel.value;
         out_in.last      = last_slot;
         if (sel.table_res == TABLE_SUMMARY) begin
            out_in.sizes_uniform      = cur_ff.sizes_uniform;
            out_in.uniform_size       = cur_ff.uniform_size;
            out_in.offsets_present    = cur_ff.offsets_present;
            out_in.sync_table_present = cur_ff.sync_table_present;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_cur_has_slots: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> mask_ff != '0)
      else $error("active bundle without pending slots");
   a_no_early_pop: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff && !last_slot |-> !q_pop)
      else $error("bundle fetched before current one is drained");
   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      take_slot && sel.table_res == TABLE_SUMMARY |-> last_slot)
      else $error("summary word is not the final word of its item");

endmodule
`default_nettype wire

FILE: design/mp4_sample_table_builder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mp4_sample_table_builder
// Builds run-length sample table words for one track at a time.
//
// Input queue: push/full with req_data; a word is taken when push is high and
// full is low. A sample word yields, in order: a closed time run, a closed
// offset run, its sync number and its size (those that apply). An end word
// yields up to two time runs, the open offset run and a summary, then the
// track state clears for the next track.
// Result queue: empty/pop with rsp_data; rsp_data holds the oldest word while
// empty is low and leaves on pop. last marks the final word of an item.
// An accepted word passes the bundle queue, the bundle register and the single
// result register. Throughput: one result word per cycle while that register
// is free or popped; an item yields one to four words. The front takes a new
// item every cycle while the two-entry bundle queue has room.
// Reset (synchronous): clears the track state and both queues. When pop stays
// low the queue fills and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module mp4_sample_table_builder
   import mstb_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   output logic          full,
   input  wire req_type  req_data,
   output logic          empty,
   input  wire logic     pop,
   output rsp_type       rsp_data
);

   logic       fq_push;
   bundle_type fq_data;
   logic       fq_full;
   logic       bq_pop;
   bundle_type bq_data;
   logic       bq_valid;

   mstb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (fq_push),
      .q_data   (fq_data),
      .q_full   (fq_full)
   );

   mstb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_data),
      .full      (fq_full),
      .pop       (bq_pop),
      .pop_data  (bq_data),
      .valid     (bq_valid)
   );

   mstb_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (bq_valid),
      .q_data   (bq_data),
      .q_pop    (bq_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

FILE: verif/mp4_sample_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp4_sample_table_checker
// Watches both queues of the sample table builder. Every accepted input word
// updates a private copy of the track state and queues the table words it
// should cause; every popped result word is compared field by field with the
// oldest queued word. Mismatches and unexpected words go to fail_count.
// ----------------------------------------------------------------------------
module mp4_sample_table_checker
   import mstb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_data,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      words_pending
);

   localparam logic [31:0] COUNT_LIMIT = 32'hFFFF_FFFF;

   logic        have_sample;
   logic [63:0] first_pts;
   logic [63:0] prev_pts;
   logic        time_open;
   logic [31:0] time_duration;
   logic [31:0] time_count;
   logic [31:0] offset_value;
   logic [31:0] offset_count;
   logic [31:0] sample_no;
   logic [31:0] sync_count;
   logic [31:0] first_size;
   logic        size_mixed;
   logic        any_offset;

   rsp_type item_words[$];
   rsp_type table_words[$];

   function automatic logic [31:0] count_up(input logic [31:0] v);
      return (v == COUNT_LIMIT) ? v : v + 32'd1;
   endfunction

   task automatic add_word(input logic [2:0] kind, input logic [31:0] cnt,
                           input logic [63:0] val);
      rsp_type w;
      w = '0;
      w.table_res = kind;
      w.count = cnt;
      w.value = val;
      item_words.push_back(w);
   endtask

   task automatic clear_track();
      have_sample = 1'b0;
      first_pts = '0;
      prev_pts = '0;
      time_open = 1'b0;
      time_duration = '0;
      time_count = '0;
      offset_value = '0;
      offset_count = '0;
      sample_no = '0;
      sync_count = '0;
      first_size = '0;
      size_mixed = 1'b0;
      any_offset = 1'b0;
   endtask

   task automatic add_duration(input logic [31:0] d);
      if (time_open && d == time_duration) begin
         time_count = count_up(time_count);
      end else begin
         if (time_open) add_word(TABLE_TIME, time_count, {32'd0, time_duration});
         time_open = 1'b1;
         time_duration = d;
         time_count = 32'd1;
      end
   endtask

   task automatic build_table_words(input req_type w);
      rsp_type s;
      logic [63:0] span;
      if (w.mode != MODE_END) begin
         if (have_sample) begin
            add_duration(w.pts[31:0] - prev_pts[31:0]);
         end else begin
            have_sample = 1'b1;
            first_pts = w.pts;
            first_size = w.byte_size;
         end
         prev_pts = w.pts;
         if (offset_count != 0 && w.cto == offset_value) begin
            offset_count = count_up(offset_count);
         end else begin
            if (offset_count != 0) add_word(TABLE_OFFSET, offset_count, {32'd0, offset_value});
            offset_value = w.cto;
            offset_count = 32'd1;
         end
         if (w.cto != 0) any_offset = 1'b1;
         sample_no = count_up(sample_no);
         if (w.is_sync) begin
            sync_count = count_up(sync_count);
            add_word(TABLE_SYNC, sample_no, '0);
         end
         if (w.byte_size != first_size) size_mixed = 1'b1;
         add_word(TABLE_SIZE, '0, {32'd0, w.byte_size});
      end else begin
         span = '0;
         if (have_sample) begin
            add_duration(w.pts[31:0] - prev_pts[31:0]);
            span = w.pts - first_pts;
         end
         if (time_open) add_word(TABLE_TIME, time_count, {32'd0, time_duration});
         if (offset_count != 0) add_word(TABLE_OFFSET, offset_count, {32'd0, offset_value});
         s = '0;
         s.table_res = TABLE_SUMMARY;
         s.count = sample_no;
         s.value = span;
         s.sizes_uniform = !size_mixed;
         s.uniform_size = first_size;
         s.offsets_present = any_offset;
         s.sync_table_present = (sync_count != sample_no);
         item_words.push_back(s);
         clear_track();
      end
      while (item_words.size() > 0) begin
         s = item_words.pop_front();
         s.last = (item_words.size() == 0);
         table_words.push_back(s);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         if (fail_count < 10)
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_table_word(input rsp_type got);
      rsp_type want;
      if (table_words.size() == 0) begin
         if (fail_count < 10) $display("%0t: word with nothing expected: %h", $time, got);
         fail_count++;
      end else begin
         want = table_words.pop_front();
         check_field("table_res", want.table_res, got.table_res);
         check_field("count", want.count, got.count);
         check_field("value", want.value, got.value);
         check_field("sizes_uniform", want.sizes_uniform, got.sizes_uniform);
         check_field("uniform_size", want.uniform_size, got.uniform_size);
         check_field("offsets_present", want.offsets_present, got.offsets_present);
         check_field("sync_table_present", want.sync_table_present,
                     got.sync_table_present);
         check_field("last", want.last, got.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_track();
         item_words.delete();
         table_words.delete();
      end else begin
         if (push && !full) build_table_words(req_data);
         if (pop && !empty) check_table_word(rsp_data);
      end
      words_pending = table_words.size();
   end

endmodule

FILE: verif/mp4_sample_table_builder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp4_sample_table_builder_test
// Drives tracks of samples and end words into the sample table builder with
// random gaps and result stalls; the checker predicts and compares the table
// words. Directed corner tracks first, then random tracks mixed with noise.
// ----------------------------------------------------------------------------
module mp4_sample_table_builder_test
   import mstb_pkg::*;
();

   localparam int STALL_LIMIT = 4000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_data;
   int      fail_count;
   int      words_pending;
   int      items_sent = 0;
   int      idle_cycles = 0;
   logic    calm;

   // stretch with no idling on either side
   assign calm = (items_sent >= 120) && (items_sent < 170);

   mp4_sample_table_builder i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   mp4_sample_table_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      pop <= calm || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic req_type sample_word(input logic [63:0] pts, input logic [31:0] cto,
                                           input logic [31:0] size, input logic sync);
      req_type w;
      w.mode = MODE_SAMPLE;
      w.pts = pts;
      w.cto = cto;
      w.byte_size = size;
      w.is_sync = sync;
      return w;
   endfunction

   function automatic req_type end_word(input logic [63:0] pts);
      req_type w;
      w = '0;
      w.mode = MODE_END;
      w.pts = pts;
      return w;
   endfunction

   // push stays high after acceptance; only an idle cycle or the end of stimulus lowers it
   task automatic send(input req_type w);
      while (!calm && $urandom_range(99) < 12) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (full) @(posedge clock);
      items_sent++;
   endtask

   task automatic random_track();
      int unsigned len;
      logic [63:0] t;
      logic [31:0] step_a;
      logic [31:0] step_b;
      logic [31:0] cto_a;
      logic [31:0] size_a;
      logic        uniform;
      logic        all_sync;
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
      t = {$urandom, $urandom};
      step_a = $urandom_range(1, 3000);
      step_b = ($urandom_range(3) == 0) ? $urandom : step_a * 2;
      cto_a = $urandom_range(1) ? 32'd0 : $urandom;
      size_a = $urandom;
      uniform = $urandom_range(1);
      all_sync = ($urandom_range(3) == 0);
      for (int k = 0; k < len; k++) begin
         send(sample_word(t,
                          ($urandom_range(4) == 0) ? 32'($urandom_range(2)) : cto_a,
                          (uniform || $urandom_range(2) != 0) ? size_a : $urandom,
                          all_sync || ($urandom_range(2) != 0)));
         t = t + (($urandom_range(3) == 0) ? step_b : step_a);
      end
      send(end_word(t));
   endtask

   task automatic noise_word();
      req_type w;
      w.mode = $urandom_range(1);
      w.pts = {$urandom, $urandom};
      w.cto = $urandom;
      w.byte_size = $urandom;
      w.is_sync = $urandom_range(1);
      send(w);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty tracks, twice in a row
      send(end_word(64'd0));
      send(end_word('1));

      // extremes, wrap of pts, backward and zero durations, two runs flushed at end
      send(sample_word(64'hFFFF_FFFF_FFFF_FFF0, 32'd0, 32'hFFFF_FFFF, 1'b1));
      send(sample_word(64'd0, 32'd0, 32'hFFFF_FFFF, 1'b1));
      send(sample_word(64'h10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
      send(sample_word(64'h0, 32'hFFFF_FFFF, 32'd0, 1'b0));
      send(sample_word(64'h0, 32'd0, 32'd0, 1'b1));
      send(end_word(64'h5));

      // single sample, not sync
      send(sample_word(64'h1234_5678_9ABC_DEF0, 32'd5, 32'd100, 1'b0));
      send(end_word(64'h1234_5678_9ABC_DEF0));

      // one even run closed by the end word, all sync
      send(sample_word(64'd1000, 32'd7, 32'd50, 1'b1));
      send(sample_word(64'd1100, 32'd7, 32'd50, 1'b1));
      send(sample_word(64'd1200, 32'd7, 32'd50, 1'b1));
      send(end_word(64'd1300));

      // durations taken from the low 32 bits only
      send(sample_word(64'd0, 32'd0, 32'd9, 1'b0));
      send(sample_word(64'h1_0000_0005, 32'd0, 32'd9, 1'b1));
      send(sample_word(64'h2_0000_000A, 32'd0, 32'd9, 1'b0));
      send(end_word(64'h2_0000_000A));

      while (items_sent < 245) begin
         if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 3)) noise_word();
         end else begin
            random_track();
         end
      end
      push <= 1'b0;

      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
